// File: rtl/b64_pkg.sv
// shared types, constants and the alphabet function of the base64 stream encoder
`timescale 1ns / 1ps

package b64_pkg;

	// characters one input byte can produce at most
	localparam int JOB_CHARS  = 4;
	localparam int CHAR_IDX_W = $clog2(JOB_CHARS);

	// depth of the queue between front and back
	localparam int JOB_DEPTH  = 2;
	localparam int JOB_PTR_W  = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
	localparam int JOB_CNT_W  = $clog2(JOB_DEPTH + 1);

	// ascii codes
	localparam logic [6:0] CHAR_PAD   = 7'h3D;
	localparam logic [6:0] CHAR_UPPER = 7'h41;
	localparam logic [6:0] CHAR_LOWER = 7'h61;
	localparam logic [6:0] CHAR_DIGIT = 7'h30;
	localparam logic [6:0] CHAR_PLUS  = 7'h2B;
	localparam logic [6:0] CHAR_SLASH = 7'h2F;

	typedef logic [CHAR_IDX_W-1:0] char_idx_t;

	// byte position in the current 3-byte group
	typedef enum logic [1:0] {
		POS_0 = 2'd0,
		POS_1 = 2'd1,
		POS_2 = 2'd2
	} pos_t;

	// input transaction
	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} in_item_t;

	// result transaction
	typedef struct packed {
		logic [6:0] ascii_char;
		logic       end_of_text;
	} out_item_t;

	// characters of one byte, handed from front to back
	typedef struct packed {
		logic [JOB_CHARS-1:0][6:0] chars;
		char_idx_t                 last_idx;
		logic                      eot;
	} job_t;

	// maps a sextet to its standard-alphabet character
	function automatic logic [6:0] b64_char(input logic [5:0] sextet);
		logic [6:0] s;
		logic [6:0] c;
		s = {1'b0, sextet};
		if (sextet < 6'd26) begin
			c = CHAR_UPPER + s;
		end else if (sextet < 6'd52) begin
			c = CHAR_LOWER + (s - 7'd26);
		end else if (sextet < 6'd62) begin
			c = CHAR_DIGIT + (s - 7'd52);
		end else if (sextet == 6'd62) begin
			c = CHAR_PLUS;
		end else begin
			c = CHAR_SLASH;
		end
		return c;
	endfunction

endpackage

// File: rtl/b64_front.sv
// front: splits each byte into sextets, tracks residue bits and builds the character job
`timescale 1ns / 1ps

module b64_front (
	input  logic             clk,
	input  logic             arst_n,
	input  b64_pkg::in_item_t item,
	input  logic             take,
	output b64_pkg::job_t    job
);

	logic [3:0]   residue_q;
	b64_pkg::pos_t pos_q;

	logic [3:0]    residue_nxt;
	b64_pkg::pos_t pos_nxt;
	logic [5:0]    sextet0;
	logic [5:0]    sextet1;
	logic [5:0]    flush;
	logic [7:0]    b;

	// sextet split and next group position
	always_comb begin
		b           = item.data_byte;
		sextet0     = b[7:2];
		sextet1     = b[5:0];
		residue_nxt = {2'b00, b[1:0]};
		pos_nxt     = b64_pkg::POS_1;
		unique case (pos_q)
			b64_pkg::POS_1: begin
				sextet0     = {residue_q[1:0], b[7:4]};
				residue_nxt = b[3:0];
				pos_nxt     = b64_pkg::POS_2;
			end
			b64_pkg::POS_2: begin
				sextet0     = {residue_q[3:0], b[7:6]};
				residue_nxt = 4'd0;
				pos_nxt     = b64_pkg::POS_0;
			end
			default: begin
				sextet0     = b[7:2];
				residue_nxt = {2'b00, b[1:0]};
				pos_nxt     = b64_pkg::POS_1;
			end
		endcase
		flush = (pos_nxt == b64_pkg::POS_1) ? {residue_nxt[1:0], 4'b0000}
		                                    : {residue_nxt[3:0], 2'b00};
	end

	// character job: data characters, then flush and padding on a final byte
	always_comb begin
		job.chars[0] = b64_pkg::b64_char(sextet0);
		job.chars[1] = (pos_q == b64_pkg::POS_2) ? b64_pkg::b64_char(sextet1)
		                                         : b64_pkg::b64_char(flush);
		job.chars[2] = b64_pkg::CHAR_PAD;
		job.chars[3] = b64_pkg::CHAR_PAD;
		job.eot      = item.final_byte;
		if (pos_q == b64_pkg::POS_2) begin
			job.last_idx = b64_pkg::char_idx_t'(1);
		end else if (!item.final_byte) begin
			job.last_idx = b64_pkg::char_idx_t'(0);
		end else if (pos_nxt == b64_pkg::POS_1) begin
			job.last_idx = b64_pkg::char_idx_t'(3);
		end else begin
			job.last_idx = b64_pkg::char_idx_t'(2);
		end
	end

	// group state, back to start after a final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			residue_q <= 4'd0;
			pos_q     <= b64_pkg::POS_0;
		end else if (take) begin
			if (item.final_byte) begin
				residue_q <= 4'd0;
				pos_q     <= b64_pkg::POS_0;
			end else begin
				residue_q <= residue_nxt;
				pos_q     <= pos_nxt;
			end
		end
	end

endmodule

// File: rtl/b64_job_fifo.sv
// short queue of character jobs between front and back
`timescale 1ns / 1ps

module b64_job_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  b64_pkg::job_t wr_job,
	output logic          full,
	input  logic          rd_en,
	output b64_pkg::job_t rd_job,
	output logic          nonempty
);

	b64_pkg::job_t                   mem_q [b64_pkg::JOB_DEPTH];
	logic [b64_pkg::JOB_PTR_W-1:0]   wr_ptr_q;
	logic [b64_pkg::JOB_PTR_W-1:0]   rd_ptr_q;
	logic [b64_pkg::JOB_CNT_W-1:0]   count_q;

	assign full     = (count_q == b64_pkg::JOB_CNT_W'(b64_pkg::JOB_DEPTH));
	assign nonempty = (count_q != '0);
	assign rd_job   = mem_q[rd_ptr_q];

	function automatic logic [b64_pkg::JOB_PTR_W-1:0] ptr_inc(
		input logic [b64_pkg::JOB_PTR_W-1:0] p
	);
		logic [b64_pkg::JOB_PTR_W-1:0] r;
		if (p == b64_pkg::JOB_PTR_W'(b64_pkg::JOB_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	// entry storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (rd_en) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/b64_back.sv
// back: walks through each job into the result register, one character a cycle unless it is held
`timescale 1ns / 1ps

module b64_back (
	input  logic               clk,
	input  logic               arst_n,
	input  b64_pkg::job_t      head_job,
	input  logic               head_valid,
	output logic               head_take,
	output b64_pkg::out_item_t result,
	output logic               empty,
	input  logic               pop
);

	b64_pkg::job_t      job_q;
	b64_pkg::char_idx_t idx_q;
	logic               busy_q;
	b64_pkg::out_item_t out_q;
	logic               out_valid_q;

	logic advance;
	logic at_last;

	assign at_last   = (idx_q == job_q.last_idx);
	assign advance   = busy_q && (!out_valid_q || pop);
	assign head_take = head_valid && (!busy_q || (advance && at_last));
	assign result    = out_q;
	assign empty     = !out_valid_q;

	// result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.ascii_char  <= job_q.chars[idx_q];
			out_q.end_of_text <= job_q.eot && at_last;
		end
	end

	// job register payload
	always_ff @(posedge clk) begin
		if (head_take) begin
			job_q <= head_job;
		end
	end

	// character index, busy and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (head_take) begin
				idx_q  <= '0;
				busy_q <= 1'b1;
			end else if (advance) begin
				idx_q <= idx_q + 1'b1;
				if (at_last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

// File: rtl/base64_stream_encoder_unit.sv
// top level of the base64 stream encoder: front, job queue and back
`timescale 1ns / 1ps

// Streaming base64 encoder, standard alphabet with '=' padding.
// Input channel: one raw byte per transaction on item, with final_byte set on
// the last byte of a message; taken at a clock edge with push high and full low.
// Result channel: one ASCII character per transaction on result; the oldest
// character stands there while empty is low and leaves at an edge with pop high.
// end_of_text marks the last character of each encoded message.
// The front turns a byte into a job of one to four characters in the same
// cycle it is taken; a two-entry job queue separates it from the back, which
// sends one character per cycle into the result register unless it is held.
// The first character of a byte passes the job queue and the back's job
// register before it reaches the result register. A byte yields 4/3
// characters on average and a final byte up to four; bytes are taken every
// cycle while the job queue has room.
// Reset clears the group position, residue bits, queue and result valid flag.
// When the receiver stalls, the result holds, the queue fills and full rises.

module base64_stream_encoder_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  b64_pkg::in_item_t  item,
	input  logic               pop,
	output logic               empty,
	output b64_pkg::out_item_t result
);

	b64_pkg::job_t front_job;
	b64_pkg::job_t head_job;
	logic          head_valid;
	logic          head_take;
	logic          take;

	assign take = push && !full;

	b64_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.take   (take),
		.job    (front_job)
	);

	b64_job_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (take),
		.wr_job   (front_job),
		.full     (full),
		.rd_en    (head_take),
		.rd_job   (head_job),
		.nonempty (head_valid)
	);

	b64_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_job   (head_job),
		.head_valid (head_valid),
		.head_take  (head_take),
		.result     (result),
		.empty      (empty),
		.pop        (pop)
	);

endmodule

// File: rtl/b64_checker.sv
// port checker for the base64 stream encoder, bound to the top level
`timescale 1ns / 1ps

module b64_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               push,
	input logic               full,
	input b64_pkg::in_item_t  item,
	input logic               pop,
	input logic               empty,
	input b64_pkg::out_item_t result
);

	// nothing waits on the result side while reset is held
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result shown during reset");

	// a waiting result holds until it is taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed before pop");

	// every result character belongs to the alphabet or is the pad
	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((result.ascii_char >= 7'h41 && result.ascii_char <= 7'h5A) ||
		            (result.ascii_char >= 7'h61 && result.ascii_char <= 7'h7A) ||
		            (result.ascii_char >= 7'h30 && result.ascii_char <= 7'h39) ||
		            result.ascii_char == 7'h2B || result.ascii_char == 7'h2F ||
		            result.ascii_char == b64_pkg::CHAR_PAD))
		else $error("result character outside the base64 alphabet");

	// a pad character that closes no message is followed by another pad
	a_pad_run: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && result.ascii_char == b64_pkg::CHAR_PAD &&
		 !result.end_of_text) |=> (!empty && result.ascii_char == b64_pkg::CHAR_PAD))
		else $error("pad run broken before end of text");

endmodule

bind base64_stream_encoder_unit b64_checker u_b64_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.push   (push),
	.full   (full),
	.item   (item),
	.pop    (pop),
	.empty  (empty),
	.result (result)
);
